// File: hdl/sws_pkg.sv
// Shared codes and constants for the stop-and-wait sender core.
package sws_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned RXFLAG_W = 8;
    localparam int unsigned SEQ_W    = 8;
    localparam int unsigned FLAG_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned TICK_W   = 32;

    localparam logic [LEN_W-1:0]  MAX_CHUNK     = 11'd1024;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd500;

    localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHUNK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RX    = 3'd5;

    localparam logic [FLAG_W-1:0] FLAG_DATA    = 3'd0;
    localparam logic [FLAG_W-1:0] FLAG_SYN     = 3'd1;
    localparam logic [FLAG_W-1:0] FLAG_ACK     = 3'd2;
    localparam logic [FLAG_W-1:0] FLAG_ACK_SYN = 3'd3;
    localparam logic [FLAG_W-1:0] FLAG_FIN     = 3'd4;
    localparam logic [FLAG_W-1:0] FLAG_FIN_ACK = 3'd5;
    localparam logic [FLAG_W-1:0] FLAG_OVER    = 3'd7;

    localparam logic [PHASE_W-1:0] PH_CLOSED      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SYN_SENT    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ESTABLISHED = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA_SENT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_OVER_SENT   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FIN_SENT    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_FINACK_SENT = 3'd6;

    localparam logic [STATUS_W-1:0] ST_WAIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_READY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAILED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd3;

endpackage

// File: hdl/stop_and_wait_sender_core.sv
// Stop-and-wait sender controller: protocol phase, sequence, pending header and retransmit timer.
//
// Takes one event word per cycle (open, send chunk, send end, close, tick, received header)
// and returns exactly one result word for each, in the cycle after acceptance, from a single
// result register. The input is stalled only while that register holds a word the downstream
// side is stalling, so without such stalls the sustained rate is one word per clock. The phase
// and 32-bit tick counter update in the accepting cycle. cfg_wdata sets the retransmit timeout in
// ticks (500 after reset); the user must write it only while no word is in flight (not enforced).
module stop_and_wait_sender_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [sws_pkg::TICK_W-1:0]      cfg_wdata,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sws_pkg::CMD_W-1:0]       command,
    input  logic [sws_pkg::LEN_W-1:0]       chunk_length,
    input  logic [sws_pkg::RXFLAG_W-1:0]    rx_flag,
    input  logic [sws_pkg::SEQ_W-1:0]       rx_seq,
    input  logic                            rx_checksum_ok,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            tx_valid,
    output logic [sws_pkg::FLAG_W-1:0]      tx_flag,
    output logic [sws_pkg::SEQ_W-1:0]       tx_seq,
    output logic [sws_pkg::LEN_W-1:0]       tx_length,
    output logic [sws_pkg::STATUS_W-1:0]    status,
    output logic [sws_pkg::PHASE_W-1:0]     phase
);

    logic [sws_pkg::TICK_W-1:0]   timeout_reg;
    logic [sws_pkg::PHASE_W-1:0]  phase_reg,   phase_next;
    logic [sws_pkg::SEQ_W-1:0]    seq_reg,     seq_next;
    logic [sws_pkg::FLAG_W-1:0]   pflag_reg,   pflag_next;
    logic [sws_pkg::LEN_W-1:0]    plen_reg,    plen_next;
    logic [sws_pkg::TICK_W-1:0]   wait_reg,    wait_next;

    logic                         out_valid_reg;
    logic                         txv_reg,     txv_next;
    logic [sws_pkg::FLAG_W-1:0]   txf_reg,     txf_next;
    logic [sws_pkg::SEQ_W-1:0]    txs_reg,     txs_next;
    logic [sws_pkg::LEN_W-1:0]    txl_reg,     txl_next;
    logic [sws_pkg::STATUS_W-1:0] st_reg,      st_next;
    logic [sws_pkg::PHASE_W-1:0]  ph_out_reg;

    logic                         accept;
    logic                         waiting;
    logic [sws_pkg::TICK_W-1:0]   wait_inc;
    logic [sws_pkg::LEN_W-1:0]    clen_sat;
    logic                         ack_ok;
    logic [sws_pkg::SEQ_W-1:0]    pend_seq;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign waiting  = (phase_reg != sws_pkg::PH_CLOSED) &&
                      (phase_reg != sws_pkg::PH_ESTABLISHED);
    assign wait_inc = wait_reg + 32'd1;
    assign clen_sat = (chunk_length > sws_pkg::MAX_CHUNK) ? sws_pkg::MAX_CHUNK : chunk_length;
    assign ack_ok   = (rx_flag == {5'd0, sws_pkg::FLAG_ACK}) && rx_checksum_ok;
    assign pend_seq = (pflag_reg == sws_pkg::FLAG_DATA) ? seq_reg : '0;

    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        pflag_next = pflag_reg;
        plen_next  = plen_reg;
        wait_next  = wait_reg;
        txv_next   = 1'b0;
        txf_next   = '0;
        txs_next   = '0;
        txl_next   = '0;
        st_next    = waiting ? sws_pkg::ST_WAIT : sws_pkg::ST_READY;

        case (command)
            sws_pkg::CMD_OPEN:
            begin
                if (phase_reg == sws_pkg::PH_CLOSED)
                begin
                    phase_next = sws_pkg::PH_SYN_SENT;
                    pflag_next = sws_pkg::FLAG_SYN;
                    plen_next  = '0;
                    wait_next  = '0;
                    txv_next   = 1'b1;
                    txf_next   = sws_pkg::FLAG_SYN;
                    st_next    = sws_pkg::ST_WAIT;
                end
                else
                begin
                    st_next = sws_pkg::ST_REFUSED;
                end
            end
            sws_pkg::CMD_CHUNK, sws_pkg::CMD_END, sws_pkg::CMD_CLOSE:
            begin
                if (phase_reg == sws_pkg::PH_ESTABLISHED)
                begin
                    wait_next = '0;
                    txv_next  = 1'b1;
                    st_next   = sws_pkg::ST_WAIT;
                    if (command == sws_pkg::CMD_CHUNK)
                    begin
                        phase_next = sws_pkg::PH_DATA_SENT;
                        pflag_next = sws_pkg::FLAG_DATA;
                        plen_next  = clen_sat;
                        txf_next   = sws_pkg::FLAG_DATA;
                        txs_next   = seq_reg;
                        txl_next   = clen_sat;
                    end
                    else if (command == sws_pkg::CMD_END)
                    begin
                        phase_next = sws_pkg::PH_OVER_SENT;
                        pflag_next = sws_pkg::FLAG_OVER;
                        plen_next  = '0;
                        txf_next   = sws_pkg::FLAG_OVER;
                    end
                    else
                    begin
                        phase_next = sws_pkg::PH_FIN_SENT;
                        pflag_next = sws_pkg::FLAG_FIN;
                        plen_next  = '0;
                        txf_next   = sws_pkg::FLAG_FIN;
                    end
                end
                else
                begin
                    st_next = sws_pkg::ST_REFUSED;
                end
            end
            sws_pkg::CMD_TICK:
            begin
                if (waiting)
                begin
                    // count the tick; on timeout restart the timer and resend the pending header
                    if (wait_inc >= timeout_reg)
                    begin
                        wait_next = '0;
                        txv_next  = 1'b1;
                        txf_next  = pflag_reg;
                        txs_next  = pend_seq;
                        txl_next  = plen_reg;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                    end
                end
            end
            sws_pkg::CMD_RX:
            begin
                case (phase_reg)
                    sws_pkg::PH_SYN_SENT, sws_pkg::PH_FIN_SENT:
                    begin
                        if (ack_ok && phase_reg == sws_pkg::PH_SYN_SENT)
                        begin
                            phase_next = sws_pkg::PH_ESTABLISHED;
                            txv_next   = 1'b1;
                            txf_next   = sws_pkg::FLAG_ACK_SYN;
                            st_next    = sws_pkg::ST_READY;
                        end
                        else if (ack_ok)
                        begin
                            phase_next = sws_pkg::PH_FINACK_SENT;
                            pflag_next = sws_pkg::FLAG_FIN_ACK;
                            plen_next  = '0;
                            wait_next  = '0;
                            txv_next   = 1'b1;
                            txf_next   = sws_pkg::FLAG_FIN_ACK;
                            st_next    = sws_pkg::ST_WAIT;
                        end
                        else
                        begin
                            phase_next = sws_pkg::PH_CLOSED;
                            wait_next  = '0;
                            st_next    = sws_pkg::ST_FAILED;
                        end
                    end
                    sws_pkg::PH_DATA_SENT:
                    begin
                        if (ack_ok && rx_seq == seq_reg)
                        begin
                            seq_next   = seq_reg + 8'd1;
                            phase_next = sws_pkg::PH_ESTABLISHED;
                            st_next    = sws_pkg::ST_READY;
                        end
                    end
                    sws_pkg::PH_OVER_SENT:
                    begin
                        if (rx_flag == {5'd0, sws_pkg::FLAG_OVER} && rx_checksum_ok)
                        begin
                            seq_next   = '0;
                            phase_next = sws_pkg::PH_ESTABLISHED;
                            st_next    = sws_pkg::ST_READY;
                        end
                    end
                    sws_pkg::PH_FINACK_SENT:
                    begin
                        phase_next = sws_pkg::PH_CLOSED;
                        wait_next  = '0;
                        st_next    = sws_pkg::ST_READY;
                    end
                    default:
                    begin
                        st_next = sws_pkg::ST_READY;
                    end
                endcase
            end
            default:
            begin
                st_next = waiting ? sws_pkg::ST_WAIT : sws_pkg::ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= sws_pkg::TIMEOUT_RESET;
            phase_reg     <= sws_pkg::PH_CLOSED;
            seq_reg       <= '0;
            pflag_reg     <= sws_pkg::FLAG_DATA;
            plen_reg      <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                seq_reg       <= seq_next;
                pflag_reg     <= pflag_next;
                plen_reg      <= plen_next;
                wait_reg      <= wait_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            txv_reg    <= txv_next;
            txf_reg    <= txf_next;
            txs_reg    <= txs_next;
            txl_reg    <= txl_next;
            st_reg     <= st_next;
            ph_out_reg <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_valid  = txv_reg;
    assign tx_flag   = txf_reg;
    assign tx_seq    = txs_reg;
    assign tx_length = txl_reg;
    assign status    = st_reg;
    assign phase     = ph_out_reg;

endmodule

// File: hdl/sws_checker.sv
// Port-level checker for the stop-and-wait sender core, with its bind.
module sws_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            tx_valid,
    input  logic [sws_pkg::FLAG_W-1:0]      tx_flag,
    input  logic [sws_pkg::SEQ_W-1:0]       tx_seq,
    input  logic [sws_pkg::LEN_W-1:0]       tx_length,
    input  logic [sws_pkg::STATUS_W-1:0]    status,
    input  logic [sws_pkg::PHASE_W-1:0]     phase
);

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_flag == '0 && tx_seq == '0 && tx_length == '0)
        else $error("header fields set without a header");

    a_tx_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |-> status == sws_pkg::ST_WAIT ||
            (tx_flag == sws_pkg::FLAG_ACK_SYN && status == sws_pkg::ST_READY))
        else $error("header sent with wrong status");

    a_length_data_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_length != '0 |-> tx_flag == sws_pkg::FLAG_DATA &&
            tx_length <= sws_pkg::MAX_CHUNK)
        else $error("length on control header or above chunk limit");

    a_fail_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sws_pkg::ST_FAILED |-> phase == sws_pkg::PH_CLOSED && !tx_valid)
        else $error("handshake failure left connection open");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(phase))
        else $error("stalled word changed");

endmodule

bind stop_and_wait_sender_core sws_checker u_sws_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_valid  (tx_valid),
    .tx_flag   (tx_flag),
    .tx_seq    (tx_seq),
    .tx_length (tx_length),
    .status    (status),
    .phase     (phase)
);

// File: bench/tb_stop_and_wait_sender_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stop-and-wait sender core with its own protocol predictor.
module tb_stop_and_wait_sender_core;
    import sws_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [LEN_W-1:0]    clen;
        logic [RXFLAG_W-1:0] rflag;
        logic [SEQ_W-1:0]    rseq;
        logic                rok;
    } event_word_t;

    typedef struct packed {
        logic                txv;
        logic [FLAG_W-1:0]   flag;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] st;
        logic [PHASE_W-1:0]  ph;
    } tx_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [TICK_W-1:0]   cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    command = '0;
    logic [LEN_W-1:0]    chunk_length = '0;
    logic [RXFLAG_W-1:0] rx_flag = '0;
    logic [SEQ_W-1:0]    rx_seq = '0;
    logic                rx_checksum_ok = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                tx_valid;
    logic [FLAG_W-1:0]   tx_flag;
    logic [SEQ_W-1:0]    tx_seq;
    logic [LEN_W-1:0]    tx_length;
    logic [STATUS_W-1:0] status;
    logic [PHASE_W-1:0]  phase;

    // sender state as predicted
    logic [PHASE_W-1:0]  snd_phase = PH_CLOSED;
    logic [SEQ_W-1:0]    snd_seq = '0;
    logic [FLAG_W-1:0]   snd_pend_flag = '0;
    logic [LEN_W-1:0]    snd_pend_len = '0;
    logic [TICK_W-1:0]   snd_wait = '0;
    logic [TICK_W-1:0]   snd_timeout = TIMEOUT_RESET;

    tx_word_t tx_expected[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int n_words = 0;
    int n_results = 0;
    int n_headers = 0;
    int n_failed = 0;
    int n_refused = 0;

    stop_and_wait_sender_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .chunk_length   (chunk_length),
        .rx_flag        (rx_flag),
        .rx_seq         (rx_seq),
        .rx_checksum_ok (rx_checksum_ok),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_valid       (tx_valid),
        .tx_flag        (tx_flag),
        .tx_seq         (tx_seq),
        .tx_length      (tx_length),
        .status         (status),
        .phase          (phase)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("stop_and_wait_sender_core verification failed");
        $finish;
    end

    function automatic tx_word_t start_wait(input logic [PHASE_W-1:0] ph,
                                            input logic [FLAG_W-1:0] flag,
                                            input logic [LEN_W-1:0] len);
        tx_word_t r;
        snd_phase = ph;
        snd_pend_flag = flag;
        snd_pend_len = len;
        snd_wait = '0;
        r.txv = 1'b1;
        r.flag = flag;
        r.seq = (flag == FLAG_DATA) ? snd_seq : '0;
        r.len = len;
        r.st = ST_WAIT;
        r.ph = ph;
        return r;
    endfunction

    function automatic tx_word_t advance_sender(input event_word_t w);
        tx_word_t r;
        logic waiting;
        logic [LEN_W-1:0] clen;
        waiting = (snd_phase != PH_CLOSED) && (snd_phase != PH_ESTABLISHED);
        r = '0;
        r.st = ST_REFUSED;
        case (w.cmd)
            CMD_OPEN:
                if (snd_phase == PH_CLOSED)
                    r = start_wait(PH_SYN_SENT, FLAG_SYN, '0);
            CMD_CHUNK:
                if (snd_phase == PH_ESTABLISHED)
                begin
                    clen = (w.clen > MAX_CHUNK) ? MAX_CHUNK : w.clen;
                    r = start_wait(PH_DATA_SENT, FLAG_DATA, clen);
                end
            CMD_END:
                if (snd_phase == PH_ESTABLISHED)
                    r = start_wait(PH_OVER_SENT, FLAG_OVER, '0);
            CMD_CLOSE:
                if (snd_phase == PH_ESTABLISHED)
                    r = start_wait(PH_FIN_SENT, FLAG_FIN, '0);
            CMD_TICK:
                if (!waiting)
                    r.st = ST_READY;
                else
                begin
                    r.st = ST_WAIT;
                    snd_wait = snd_wait + 1'b1;
                    if (snd_wait >= snd_timeout)
                    begin
                        snd_wait = '0;
                        r.txv = 1'b1;
                        r.flag = snd_pend_flag;
                        r.seq = (snd_pend_flag == FLAG_DATA) ? snd_seq : '0;
                        r.len = snd_pend_len;
                    end
                end
            CMD_RX:
            begin
                r.st = ST_READY;
                case (snd_phase)
                    PH_SYN_SENT, PH_FIN_SENT:
                        if (w.rflag == FLAG_ACK && w.rok)
                        begin
                            if (snd_phase == PH_SYN_SENT)
                            begin
                                snd_phase = PH_ESTABLISHED;
                                r.txv = 1'b1;
                                r.flag = FLAG_ACK_SYN;
                            end
                            else
                                r = start_wait(PH_FINACK_SENT, FLAG_FIN_ACK, '0);
                        end
                        else
                        begin
                            snd_phase = PH_CLOSED;
                            snd_wait = '0;
                            r.st = ST_FAILED;
                        end
                    PH_DATA_SENT:
                        if (w.rflag == FLAG_ACK && w.rok && w.rseq == snd_seq)
                        begin
                            snd_seq = snd_seq + 1'b1;
                            snd_phase = PH_ESTABLISHED;
                        end
                        else
                            r.st = ST_WAIT;
                    PH_OVER_SENT:
                        if (w.rflag == FLAG_OVER && w.rok)
                        begin
                            snd_seq = '0;
                            snd_phase = PH_ESTABLISHED;
                        end
                        else
                            r.st = ST_WAIT;
                    PH_FINACK_SENT:
                    begin
                        snd_phase = PH_CLOSED;
                        snd_wait = '0;
                    end
                    default: ;
                endcase
            end
            default:
                r.st = waiting ? ST_WAIT : ST_READY;
        endcase
        r.ph = snd_phase;
        return r;
    endfunction

    function automatic event_word_t mk(input logic [CMD_W-1:0] cmd, input int unsigned clen,
                                       input int unsigned rflag, input int unsigned rseq,
                                       input bit rok);
        event_word_t w;
        w.cmd = cmd;
        w.clen = LEN_W'(clen);
        w.rflag = RXFLAG_W'(rflag);
        w.rseq = SEQ_W'(rseq);
        w.rok = rok;
        return w;
    endfunction

    // well-formed traffic for the current phase, with some noise mixed in
    function automatic event_word_t pick_word();
        event_word_t w;
        int unsigned r;
        w.cmd = CMD_W'($urandom_range(7));
        w.clen = LEN_W'($urandom_range(2047));
        w.rflag = RXFLAG_W'($urandom_range(255));
        w.rseq = SEQ_W'($urandom_range(255));
        w.rok = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (r >= 15)
        begin
            case (snd_phase)
                PH_CLOSED:
                    w.cmd = (r < 85) ? CMD_OPEN : CMD_TICK;
                PH_ESTABLISHED:
                begin
                    if (r < 65)
                    begin
                        w.cmd = CMD_CHUNK;
                        if ($urandom_range(9) != 0)
                            w.clen = LEN_W'($urandom_range(32'(MAX_CHUNK)));
                    end
                    else if (r < 82)
                        w.cmd = CMD_END;
                    else if (r < 95)
                        w.cmd = CMD_CLOSE;
                    else
                        w.cmd = CMD_OPEN;
                end
                PH_SYN_SENT, PH_FIN_SENT:
                begin
                    w.cmd = (r < 88) ? CMD_RX : CMD_TICK;
                    if (r < 75)
                    begin
                        w.rflag = FLAG_ACK;
                        w.rok = 1'b1;
                    end
                end
                PH_DATA_SENT:
                begin
                    w.cmd = (r >= 65 && r < 85) ? CMD_TICK : CMD_RX;
                    if (r < 65)
                    begin
                        w.rflag = FLAG_ACK;
                        w.rok = 1'b1;
                        w.rseq = snd_seq;
                    end
                    else if (r >= 92)
                    begin
                        w.rflag = FLAG_ACK;
                        w.rseq = snd_seq + SEQ_W'($urandom_range(1));
                    end
                end
                PH_OVER_SENT:
                begin
                    w.cmd = (r >= 65 && r < 85) ? CMD_TICK : CMD_RX;
                    if (r < 65)
                    begin
                        w.rflag = FLAG_OVER;
                        w.rok = 1'b1;
                    end
                    else if (r >= 92)
                        w.rflag = FLAG_OVER;
                end
                default:
                    w.cmd = (r < 60) ? CMD_RX : CMD_TICK;
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input event_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        command        <= w.cmd;
        chunk_length   <= w.clen;
        rx_flag        <= w.rflag;
        rx_seq         <= w.rseq;
        rx_checksum_ok <= w.rok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tx_expected.push_back(advance_sender(w));
        n_words++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tx_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [TICK_W-1:0] ticks);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(negedge clk);
        cfg_we <= 1'b0;
        snd_timeout = ticks;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        tx_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tx_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got flag %0d status %0d",
                         $time, tx_flag, status);
            end
            else
            begin
                want = tx_expected.pop_front();
                n_results++;
                if (want.txv)
                    n_headers++;
                if (want.st == ST_FAILED)
                    n_failed++;
                if (want.st == ST_REFUSED)
                    n_refused++;
                check_field("tx_valid", want.txv, tx_valid);
                check_field("tx_flag", want.flag, tx_flag);
                check_field("tx_seq", want.seq, tx_seq);
                check_field("tx_length", want.len, tx_length);
                check_field("status", want.st, status);
                check_field("phase", want.ph, phase);
            end
        end
    end

    task automatic test_protocol_basics();
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_CHUNK, 5, 0, 0, 0));
        send_word(mk(CMD_END, 0, 0, 0, 0));
        send_word(mk(CMD_CLOSE, 0, 0, 0, 0));
        send_word(mk(3'd6, 2047, 255, 255, 1));
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(3'd7, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, 255, 255, 1));
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 0));
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_CHUNK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 1, 1));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_CHUNK, 2047, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 1, 1));
        send_word(mk(CMD_END, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_OVER, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_OVER, 0, 1));
        send_word(mk(CMD_CLOSE, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_RX, 0, 0, 0, 0));
    endtask

    task automatic test_retransmit();
        set_timeout(32'd1);
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_CHUNK, 1024, 0, 0, 0));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_END, 0, 0, 0, 0));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_OVER, 0, 1));
        send_word(mk(CMD_CLOSE, 0, 0, 0, 0));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_FIN, 0, 1));
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_CLOSE, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 0));
        set_timeout(32'd0);
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        set_timeout(32'd3);
        send_word(mk(CMD_CLOSE, 0, 0, 0, 0));
        repeat (3) send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
        set_timeout(32'hFFFF_FFFF);
        send_word(mk(CMD_OPEN, 0, 0, 0, 0));
        repeat (2) send_word(mk(CMD_TICK, 0, 0, 0, 0));
        send_word(mk(CMD_RX, 0, FLAG_ACK, 0, 1));
    endtask

    task automatic test_random_traffic();
        int unsigned idle_set[4] = '{0, 49, 0, 14};
        int unsigned stall_set[4] = '{0, 0, 49, 14};
        logic [TICK_W-1:0] ticks_set[4] = '{32'd3, 32'd1, 32'd0, TIMEOUT_RESET};
        for (int p = 0; p < 4; p++)
        begin
            set_timeout(ticks_set[p]);
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            repeat (115) send_word(pick_word());
        end
    endtask

    task automatic test_backpressure();
        set_timeout(32'd2);
        idle_pct = 0;
        stall_pct = 0;
        hold_trigger++;
        repeat (120) send_word(pick_word());
    endtask

    task automatic test_sequence_wrap();
        event_word_t w;
        set_timeout(32'd2);
        idle_pct = 14;
        stall_pct = 14;
        while (snd_phase != PH_ESTABLISHED)
            send_word(pick_word());
        repeat (270)
        begin
            send_word(mk(CMD_CHUNK, $urandom_range(32'(MAX_CHUNK)), $urandom_range(255),
                         $urandom_range(255), 1'($urandom_range(1))));
            if ($urandom_range(9) == 0)
                send_word(mk(CMD_TICK, $urandom_range(2047), $urandom_range(255),
                             $urandom_range(255), 1'($urandom_range(1))));
            w = mk(CMD_RX, $urandom_range(2047), FLAG_ACK, snd_seq, 1'b1);
            send_word(w);
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_protocol_basics();
        test_retransmit();
        test_random_traffic();
        test_backpressure();
        test_sequence_wrap();
        settle();
        $display("Ran %0d event words through open, data, end and close exchanges,", n_words);
        $display("checked %0d results: %0d headers sent, %0d handshake failures, %0d refusals",
                 n_results, n_headers, n_failed, n_refused);
        if (errors == 0)
            $display("stop_and_wait_sender_core verification clean");
        else
            $display("stop_and_wait_sender_core verification failed");
        $finish;
    end

endmodule

// File: files.f
hdl/sws_pkg.sv
hdl/stop_and_wait_sender_core.sv
hdl/sws_checker.sv
bench/tb_stop_and_wait_sender_core.sv
